@@ hdl/eeb_pkg.sv @@
package eeb_pkg;

  // width of every field on the ports
  localparam int unsigned FIELD_W = 32;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // take operands, seed coefficient pairs
    logic div_init;  // clear divider, load dividend
    logic div_step;  // one restoring divide bit
    logic update;    // rotate remainders and coefficient pairs
    logic out_load;  // capture result into output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic rem_lo_zero;
  } sts_t;

endpackage

@@ hdl/eeb_dp.sv @@
module eeb_dp import eeb_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  logic [DATA_WIDTH-1:0] opd_a,
  input  logic [DATA_WIDTH-1:0] opd_b,
  output sts_t                  sts,
  output logic [DATA_WIDTH-1:0] res_div,
  output logic [DATA_WIDTH-1:0] res_cx,
  output logic [DATA_WIDTH-1:0] res_cy
);

  logic [DATA_WIDTH-1:0] rem_hi_r, rem_lo_r;
  logic [DATA_WIDTH-1:0] cx_cur_r, cy_cur_r, cx_nxt_r, cy_nxt_r;
  logic [DATA_WIDTH-1:0] part_r, dvd_r;   // partial remainder, dividend shifter
  logic [DATA_WIDTH-1:0] acc_x_r, acc_y_r; // q * coeff, built MSB first
  logic [DATA_WIDTH-1:0] res_div_r, res_cx_r, res_cy_r;

  logic [DATA_WIDTH:0]   shifted, diff;
  logic                  qbit;

  // restoring divide bit: remainder < divisor keeps diff within W+1 bits
  assign shifted = {part_r, dvd_r[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, rem_lo_r};
  assign qbit    = ~diff[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_hi_r <= opd_a;
      rem_lo_r <= opd_b;
      cx_cur_r <= DATA_WIDTH'(1);
      cy_cur_r <= '0;
      cx_nxt_r <= '0;
      cy_nxt_r <= DATA_WIDTH'(1);
    end else if (cmd.update) begin
      rem_hi_r <= rem_lo_r;
      rem_lo_r <= part_r;
      cx_cur_r <= cx_nxt_r;
      cy_cur_r <= cy_nxt_r;
      cx_nxt_r <= cx_cur_r - acc_x_r;
      cy_nxt_r <= cy_cur_r - acc_y_r;
    end

    if (cmd.div_init) begin
      part_r  <= '0;
      dvd_r   <= rem_hi_r;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (cmd.div_step) begin
      part_r  <= qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      dvd_r   <= {dvd_r[DATA_WIDTH-2:0], 1'b0};
      // Horner form of q * coeff, wraps mod 2^W
      acc_x_r <= {acc_x_r[DATA_WIDTH-2:0], 1'b0} + (qbit ? cx_nxt_r : '0);
      acc_y_r <= {acc_y_r[DATA_WIDTH-2:0], 1'b0} + (qbit ? cy_nxt_r : '0);
    end

    if (cmd.out_load) begin
      res_div_r <= rem_hi_r;
      res_cx_r  <= cx_cur_r;
      res_cy_r  <= cy_cur_r;
    end
  end

  assign sts.rem_lo_zero = (rem_lo_r == '0);
  assign res_div = res_div_r;
  assign res_cx  = res_cx_r;
  assign res_cy  = res_cy_r;

endmodule

@@ hdl/eeb_ctrl.sv @@
module eeb_ctrl import eeb_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.rem_lo_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall)       out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hdl/extended_euclid_bezout_32_core.sv @@
// Each Euclid step is a bit-serial restoring divide between a check state and an update state.
// The divider loop is shared, so a new transaction is taken only after the result is loaded.
// The result sits in an output register, so a new input is taken while it waits.
// Reset (rst_n, synchronous, active low) clears the controller and out_valid.
module extended_euclid_bezout_32_core import eeb_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FIELD_W-1:0]        in_first_operand,
  input  logic [FIELD_W-1:0]        in_second_operand,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [FIELD_W-1:0]        out_divisor,
  output logic signed [FIELD_W-1:0] out_coeff_first,
  output logic signed [FIELD_W-1:0] out_coeff_second
);

  cmd_t                  cmd;
  sts_t                  sts;
  logic [DATA_WIDTH-1:0] opd_a, opd_b;
  logic [DATA_WIDTH-1:0] res_div, res_cx, res_cy;

  // operands truncate or zero-extend to the arithmetic width
  assign opd_a = DATA_WIDTH'(in_first_operand);
  assign opd_b = DATA_WIDTH'(in_second_operand);

  // sequencer: check / divide / update loop, output handshake
  eeb_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // remainders, coefficient pairs, bit-serial divider, output register
  eeb_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .opd_a   (opd_a),
    .opd_b   (opd_b),
    .sts     (sts),
    .res_div (res_div),
    .res_cx  (res_cx),
    .res_cy  (res_cy)
  );

  // results are mod 2^W values, masked to the field width
  assign out_divisor      = FIELD_W'(res_div);
  assign out_coeff_first  = $signed(FIELD_W'(res_cx));
  assign out_coeff_second = $signed(FIELD_W'(res_cy));

endmodule

@@ hdl/eeb_chk.sv @@
module eeb_chk import eeb_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [FIELD_W-1:0]        out_divisor,
  input logic signed [FIELD_W-1:0] out_coeff_first,
  input logic signed [FIELD_W-1:0] out_coeff_second
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_divisor)
      && $stable(out_coeff_first) && $stable(out_coeff_second))
    else $error("stalled result changed");

  // accepted input makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after input transaction");

  // a new result only appears at the end of a busy period
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in progress");

  // zero gcd only from both operands zero: coefficients 1, 0
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divisor == '0) |->
      (out_coeff_first == FIELD_W'(1)) && (out_coeff_second == '0))
    else $error("zero divisor with wrong coefficients");

endmodule

bind extended_euclid_bezout_32_core eeb_chk u_eeb_chk (.*);
